/* hdl/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 hash engine.
// Used by sha256_hash_engine and sha256_checker; depends on nothing else.
`default_nettype none

package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam int unsigned NumRounds  = 64;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned HashWords  = 8;

    localparam logic [7:0] PadByte = 8'h80;
    // Last byte position of a block that still leaves room for the length.
    localparam logic [5:0] LastShortPos = 6'd55;

    localparam logic [31:0] InitHash [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

/* hdl/sha256_hash_engine.sv */
// SHA-256 hash engine: byte-wide message requests in, eight digest word requests out.
// Depends on sha256_pkg for request types, round constants and round functions.
// A byte request is taken while idle; the byte that fills a block starts a compression of
// 64 rounds of the shared round unit plus a fold into the chaining value.
// An end request builds a padded block and, if needed, a length block, compresses each and
// emits eight words, one per cycle the output is not stalled. Input is stalled meanwhile.
// Reset (synchronous, active low) idles the sequencer, loads the initial hash values and
// clears the bit count; the message block and working variables are not reset.
`default_nettype none

module sha256_hash_engine (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  sha256_pkg::t_in_item  i_data,
    output logic                  o_valid,
    input  wire                   i_stall,
    output sha256_pkg::t_out_item o_data
);
    import sha256_pkg::*;

    // Sequencer states. ROUND runs the shared round unit once per cycle, FOLD adds the
    // working variables into the chaining value, PAD and LENGTH build padded blocks and
    // EMIT walks the eight digest words out.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ROUND  = 6'b000010,
        S_FOLD   = 6'b000100,
        S_PAD    = 6'b001000,
        S_LENGTH = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    // What kind of block is being compressed decides where the sequencer goes after FOLD.
    typedef enum logic [2:0] {
        PH_DATA = 3'b001,
        PH_PAD  = 3'b010,
        PH_LEN  = 3'b100
    } t_phase;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic        r_end, n_end;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_oidx, n_oidx;
    logic [63:0] r_bits, n_bits;
    logic [31:0] r_hash [HashWords];
    logic [31:0] n_hash [HashWords];
    logic [31:0] r_work [HashWords];
    logic [31:0] n_work [HashWords];
    // Message schedule window: entry 0 always holds the word for the current round.
    logic [31:0] r_sched [BlockWords];
    logic [31:0] n_sched [BlockWords];

    logic        in_take;
    logic [5:0]  in_pos;
    logic [5:0]  pad_pos;
    logic [31:0] sched_next;
    logic [31:0] t1;
    logic [31:0] t2;

    assign o_stall = (r_state != S_IDLE);
    assign in_take = i_valid && (r_state == S_IDLE);
    assign in_pos  = r_bits[8:3];
    assign pad_pos = r_bits[8:3];

    assign o_valid            = (r_state == S_EMIT);
    assign o_data.digest_word = r_hash[r_oidx];
    assign o_data.word_index  = r_oidx;
    assign o_data.last_word   = (r_oidx == 3'(HashWords - 1));

    // Shared round unit: one schedule word and one compression round per cycle.
    assign sched_next = r_sched[0] + small_sigma0(r_sched[1]) + r_sched[9]
                      + small_sigma1(r_sched[14]);
    assign t1 = r_work[7] + big_sigma1(r_work[4]) + choose(r_work[4], r_work[5], r_work[6])
              + RoundK[r_round] + r_sched[0];
    assign t2 = big_sigma0(r_work[0]) + majority(r_work[0], r_work[1], r_work[2]);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_end   = r_end;
        n_round = r_round;
        n_oidx  = r_oidx;
        n_bits  = r_bits;
        n_hash  = r_hash;
        n_work  = r_work;
        n_sched = r_sched;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_data.byte_present) begin
                        for (int i = 0; i < BlockWords; i++) begin
                            for (int k = 0; k < 4; k++) begin
                                if (in_pos == 6'(4 * i + k)) begin
                                    n_sched[i][31 - 8 * k -: 8] = i_data.data_byte;
                                end
                            end
                        end
                        n_bits = r_bits + 64'd8;
                    end
                    if (i_data.byte_present && (in_pos == 6'd63)) begin
                        // Block is full: compress it, then pad if this also ends the message.
                        n_end   = i_data.end_of_message;
                        n_phase = PH_DATA;
                        n_work  = r_hash;
                        n_round = '0;
                        n_state = S_ROUND;
                    end else if (i_data.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                for (int i = 0; i < BlockWords - 1; i++) begin
                    n_sched[i] = r_sched[i + 1];
                end
                n_sched[BlockWords - 1] = sched_next;
                n_work[7] = r_work[6];
                n_work[6] = r_work[5];
                n_work[5] = r_work[4];
                n_work[4] = r_work[3] + t1;
                n_work[3] = r_work[2];
                n_work[2] = r_work[1];
                n_work[1] = r_work[0];
                n_work[0] = t1 + t2;
                n_round   = r_round + 6'd1;
                if (r_round == 6'(NumRounds - 1)) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                for (int i = 0; i < HashWords; i++) begin
                    n_hash[i] = r_hash[i] + r_work[i];
                end
                case (r_phase)
                    PH_DATA: n_state = r_end ? S_PAD : S_IDLE;
                    PH_PAD:  n_state = S_LENGTH;
                    PH_LEN: begin
                        n_oidx  = '0;
                        n_state = S_EMIT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_PAD: begin
                // Bytes before the pad position are message data; then 0x80 and zeros.
                for (int i = 0; i < BlockWords; i++) begin
                    for (int k = 0; k < 4; k++) begin
                        if (pad_pos == 6'(4 * i + k)) begin
                            n_sched[i][31 - 8 * k -: 8] = PadByte;
                        end else if (pad_pos < 6'(4 * i + k)) begin
                            n_sched[i][31 - 8 * k -: 8] = 8'h00;
                        end
                    end
                end
                if (pad_pos <= LastShortPos) begin
                    n_sched[BlockWords - 2] = r_bits[63:32];
                    n_sched[BlockWords - 1] = r_bits[31:0];
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_PAD;
                end
                n_end   = 1'b0;
                n_work  = r_hash;
                n_round = '0;
                n_state = S_ROUND;
            end
            S_LENGTH: begin
                // Extra block holding only zeros and the message length.
                for (int i = 0; i < BlockWords - 2; i++) begin
                    n_sched[i] = '0;
                end
                n_sched[BlockWords - 2] = r_bits[63:32];
                n_sched[BlockWords - 1] = r_bits[31:0];
                n_phase = PH_LEN;
                n_work  = r_hash;
                n_round = '0;
                n_state = S_ROUND;
            end
            S_EMIT: begin
                if (!i_stall) begin
                    if (r_oidx == 3'(HashWords - 1)) begin
                        n_hash  = InitHash;
                        n_bits  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DATA;
            r_end   <= 1'b0;
            r_round <= '0;
            r_oidx  <= '0;
            r_bits  <= '0;
            r_hash  <= InitHash;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_end   <= n_end;
            r_round <= n_round;
            r_oidx  <= n_oidx;
            r_bits  <= n_bits;
            r_hash  <= n_hash;
        end
    end

    // Data path registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_sched <= n_sched;
    end

endmodule

`default_nettype wire

/* hdl/sha256_checker.sv */
// Port-level checker for the SHA-256 hash engine, bound into sha256_hash_engine.
// Depends on sha256_pkg for the request types.
`default_nettype none

module sha256_port_checker (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_valid,
    input wire                   o_stall,
    input sha256_pkg::t_in_item  i_data,
    input wire                   o_valid,
    input wire                   i_stall,
    input sha256_pkg::t_out_item o_data
);
    import sha256_pkg::*;

    // A stalled digest request holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled digest request changed");

    // The engine takes no input while digest words are pending.
    a_no_input_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input not stalled during digest output");

    // The last flag marks exactly the eighth word.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_word == (o_data.word_index == 3'd7)))
        else $error("last_word does not match word_index");

    // Words follow one another in order with no gap.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.last_word |=>
            o_valid && (o_data.word_index == 3'($past(o_data.word_index) + 3'd1)))
        else $error("digest word index did not advance");

    // Reset leaves no output pending.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind sha256_hash_engine sha256_port_checker u_sha256_port_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

/* dv/sha256_checker.sv */
// Checker for sha256_hash_engine: watches the request and digest channels, predicts digests.
// Depends on sha256_pkg for the request and digest word types.
`timescale 1ns / 1ps

module sha256_checker
    import sha256_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_req_valid,
    input  wire       i_req_stall,
    input  t_in_item  i_req,
    input  wire       i_dig_valid,
    input  wire       i_dig_stall,
    input  t_out_item i_dig,
    output int        o_pending,
    output int        o_failures
);

    localparam bit [7:0] PadMarker = 8'h80;

    localparam bit [31:0] HashStart [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    bit [31:0] chain [8];
    bit [31:0] block_words [16];
    bit [63:0] msg_bits;
    t_out_item expected_words [$];
    int        mismatches = 0;

    function automatic bit [31:0] rotr(input bit [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic put_byte(input int unsigned pos, input bit [7:0] value);
        block_words[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = value;
    endtask

    // One 64-round compression of block_words into the chaining value.
    task automatic compress_block();
        bit [31:0] w [16];
        bit [31:0] v [8];
        bit [31:0] wt, t1, t2, x15, x2;
        w = block_words;
        v = chain;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                x15 = w[(r + 1) % 16];
                x2  = w[(r + 14) % 16];
                wt  = w[r % 16] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                    + w[(r + 9) % 16] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
                w[r % 16] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) begin
            chain[j] = chain[j] + v[j];
        end
    endtask

    // Absorbs one accepted request; an end request queues the eight digest words.
    task automatic absorb_request(input t_in_item req);
        int unsigned pos;
        t_out_item   word;
        if (req.byte_present) begin
            pos = 32'(msg_bits[8:3]);
            put_byte(pos, req.data_byte);
            msg_bits = msg_bits + 64'd8;
            if (pos == 63) begin
                compress_block();
            end
        end
        if (req.end_of_message) begin
            pos = 32'(msg_bits[8:3]);
            put_byte(pos, PadMarker);
            for (int unsigned j = pos + 1; j < 64; j++) begin
                put_byte(j, 8'h00);
            end
            // No room left for the length: it goes into an extra block.
            if (pos >= 56) begin
                compress_block();
                foreach (block_words[j]) begin
                    block_words[j] = '0;
                end
            end
            block_words[14] = msg_bits[63:32];
            block_words[15] = msg_bits[31:0];
            compress_block();
            for (int j = 0; j < 8; j++) begin
                word.digest_word = chain[j];
                word.word_index  = 3'(j);
                word.last_word   = (j == 7);
                expected_words.push_back(word);
            end
            chain    = HashStart;
            msg_bits = '0;
        end
    endtask

    task automatic check_word(input t_out_item got);
        t_out_item want;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] digest word %08h index %0d arrived with nothing expected",
                         $realtime, got.digest_word, got.word_index);
            end
        end else begin
            want = expected_words.pop_front();
            if (got.digest_word !== want.digest_word || got.word_index !== want.word_index
                    || got.last_word !== want.last_word) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] digest expected %08h idx %0d last %0b, got %08h idx %0d last %0b",
                             $realtime, want.digest_word, want.word_index, want.last_word,
                             got.digest_word, got.word_index, got.last_word);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chain    = HashStart;
            msg_bits = '0;
            foreach (block_words[j]) begin
                block_words[j] = '0;
            end
            expected_words.delete();
        end else begin
            if (i_dig_valid && !i_dig_stall) begin
                check_word(i_dig);
            end
            if (i_req_valid && !i_req_stall) begin
                absorb_request(i_req);
            end
        end
        o_pending  <= expected_words.size();
        o_failures <= mismatches;
    end

endmodule

/* dv/tb_sha256_hash_engine.sv */
// Top testbench for sha256_hash_engine: drives byte requests and digest stalls, gives the verdict.
// Depends on sha256_pkg, sha256_hash_engine and sha256_checker.
`timescale 1ns / 1ps

module tb_sha256_hash_engine;
    import sha256_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    t_in_item  req       = '0;
    logic      req_stall;
    logic      dig_valid;
    logic      dig_stall = 1'b0;
    t_out_item dig;
    int        pending;
    int        failures;

    // When set, the request side sends back to back for the current message.
    bit        tx_calm = 1'b0;
    // Every request the engine has taken, idle requests included.
    int        items_sent = 0;

    always #5 clk = ~clk;

    sha256_hash_engine i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_stall (req_stall),
        .i_data  (req),
        .o_valid (dig_valid),
        .i_stall (dig_stall),
        .o_data  (dig)
    );

    sha256_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .i_req_stall (req_stall),
        .i_req       (req),
        .i_dig_valid (dig_valid),
        .i_dig_stall (dig_stall),
        .i_dig       (dig),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    // Presents one request after a random gap and holds it until the engine takes it.
    // The request is accepted on the edge where valid is high and stall is low.
    task automatic send_request(input t_in_item r);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
        items_sent++;
    endtask

    // An idle request carries neither a byte nor the end flag; the engine must ignore it.
    task automatic send_idle();
        t_in_item r;
        r.data_byte      = 8'($urandom);
        r.byte_present   = 1'b0;
        r.end_of_message = 1'b0;
        send_request(r);
    endtask

    // Sends a message of len random bytes. With fold_end the end flag rides on the last
    // byte; otherwise a separate end request without a byte closes the message.
    task automatic send_message(input int len, input bit fold_end);
        t_in_item r;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_idle();
            end
            r.data_byte      = 8'($urandom);
            r.byte_present   = 1'b1;
            r.end_of_message = fold_end && (i == len - 1);
            send_request(r);
        end
        if (!fold_end || len == 0) begin
            r.data_byte      = 8'($urandom);
            r.byte_present   = 1'b0;
            r.end_of_message = 1'b1;
            send_request(r);
        end
    endtask

    // Holds the request side off until every predicted digest word has come back. The
    // first edge lets the checker's count catch up with the request just accepted.
    task automatic drain_digests();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Digest side: before each word a random number of stalled cycles, with calm
    // stretches in which every word is taken at once.
    initial begin
        int unsigned hold;
        int          served;
        bit          calm;
        served = 0;
        calm   = 1'b0;
        forever begin
            if (served % 24 == 0) begin
                calm = ($urandom_range(0, 2) == 0);
            end
            hold = calm ? 0 : $urandom_range(0, 4);
            if (hold != 0) begin
                dig_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            dig_stall <= 1'b0;
            do @(posedge clk); while (dig_valid !== 1'b1);
            served++;
        end
    end

    initial begin
        t_in_item r;
        int       len;
        int       pick;
        int       edge_len [8];
        edge_len = '{54, 55, 56, 57, 62, 63, 64, 65};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. An idle request first: it must leave no trace.
        r = '{data_byte: 8'hff, byte_present: 1'b0, end_of_message: 1'b0};
        send_request(r);
        // The empty message: an end request with no byte and no earlier bytes.
        r = '{data_byte: 8'ha5, byte_present: 1'b0, end_of_message: 1'b1};
        send_request(r);
        // "abc" closed by a separate end request.
        r = '{data_byte: 8'h61, byte_present: 1'b1, end_of_message: 1'b0};
        send_request(r);
        r.data_byte = 8'h62;
        send_request(r);
        r.data_byte = 8'h63;
        send_request(r);
        r = '{data_byte: 8'h00, byte_present: 1'b0, end_of_message: 1'b1};
        send_request(r);
        // Single bytes at both extremes with the end flag on the same request, so the
        // byte is absorbed before padding starts.
        r = '{data_byte: 8'h00, byte_present: 1'b1, end_of_message: 1'b1};
        send_request(r);
        r = '{data_byte: 8'hff, byte_present: 1'b1, end_of_message: 1'b1};
        send_request(r);
        // Bytes around an idle request, then a byte equal to the pad marker with the end.
        r = '{data_byte: 8'hff, byte_present: 1'b1, end_of_message: 1'b0};
        send_request(r);
        r = '{data_byte: 8'h5a, byte_present: 1'b0, end_of_message: 1'b0};
        send_request(r);
        r = '{data_byte: 8'h00, byte_present: 1'b1, end_of_message: 1'b0};
        send_request(r);
        r = '{data_byte: 8'h80, byte_present: 1'b1, end_of_message: 1'b1};
        send_request(r);
        drain_digests();

        // Random part. Lengths around the block boundary come first: 55 bytes still leave
        // room for the length, 56 to 63 need a second padding block, 64 fills a block.
        foreach (edge_len[i]) begin
            if (edge_len[i] inside {55, 56, 63, 64}) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                send_message(edge_len[i], 1'($urandom_range(0, 1)));
            end
        end
        while (items_sent < 470) begin
            pick = $urandom_range(0, 15);
            if (pick < 9) begin
                len = $urandom_range(0, 8);
            end else if (pick < 11) begin
                len = edge_len[$urandom_range(0, 7)];
            end else if (pick < 14) begin
                len = $urandom_range(9, 60);
            end else begin
                len = $urandom_range(100, 130);
            end
            tx_calm = ($urandom_range(0, 3) == 0);
            send_message(len, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0) begin
                drain_digests();
            end
        end

        // Let the last digest words come back, then give the engine time to settle.
        drain_digests();
        repeat (150) @(posedge clk);
        if (failures == 0 && pending == 0) begin
            $display("sha256_hash_engine: match");
        end else begin
            $display("sha256_hash_engine: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #6000000;
        $display("sha256_hash_engine: mismatch");
        $finish;
    end

endmodule
